### src/nec_ir_pulse_decoder_macros.svh
// Assertion macros for the NEC IR pulse decoder.
// Used by nec_ir_pulse_decoder.sv; expects clk and rst_n in scope.
`ifndef NEC_IR_PULSE_DECODER_MACROS_SVH
`define NEC_IR_PULSE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NIR_ASSERT_IMPL(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("nir: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define NIR_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("nir: next-cycle check failed");

`endif

### src/nir_pkg.sv
// Shared types and constants for the NEC IR pulse decoder.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package nir_pkg;

    // Field widths
    localparam int unsigned US_W     = 16;
    localparam int unsigned CODE_W   = 32;
    localparam int unsigned BUTTON_W = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned BITS_W   = 6;
    localparam int unsigned CFG_IDX_W = 8;

    // Command codes on the event channel
    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MAX  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MAX = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN        = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK_MAX     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SPACE_MAX    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD    = 8'd7;

    // Reset values of the timing registers, in microseconds
    localparam logic [US_W-1:0] RST_LEADER_MARK_MIN  = 16'd8500;
    localparam logic [US_W-1:0] RST_LEADER_MARK_MAX  = 16'd9500;
    localparam logic [US_W-1:0] RST_LEADER_SPACE_MIN = 16'd4000;
    localparam logic [US_W-1:0] RST_LEADER_SPACE_MAX = 16'd5000;
    localparam logic [US_W-1:0] RST_PULSE_MIN        = 16'd400;
    localparam logic [US_W-1:0] RST_BIT_MARK_MAX     = 16'd700;
    localparam logic [US_W-1:0] RST_BIT_SPACE_MAX    = 16'd1800;
    localparam logic [US_W-1:0] RST_ONE_THRESHOLD    = 16'd1000;

    // Decoder phase
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_LMARK  = 3'd1,
        PH_LSPACE = 3'd2,
        PH_BMARK  = 3'd3,
        PH_BSPACE = 3'd4
    } nir_phase_t;

    // Timing register bank as seen by the decoder
    typedef struct packed {
        logic [US_W-1:0] leader_mark_min;
        logic [US_W-1:0] leader_mark_max;
        logic [US_W-1:0] leader_space_min;
        logic [US_W-1:0] leader_space_max;
        logic [US_W-1:0] pulse_min;
        logic [US_W-1:0] bit_mark_max;
        logic [US_W-1:0] bit_space_max;
        logic [US_W-1:0] one_threshold;
    } nir_cfg_t;

endpackage

`default_nettype wire

### src/nir_evt_if.sv
// Event channel: edge or timeout beats into the decoder.
// Depends on nir_pkg.
`default_nettype none

interface nir_evt_if;
    import nir_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    logic [US_W-1:0] elapsed_us;

    modport source (output valid, command, elapsed_us, input ready);
    modport sink   (input valid, command, elapsed_us, output ready);
endinterface

`default_nettype wire

### src/nir_res_if.sv
// Result channel: one beat per accepted event.
// Depends on nir_pkg.
`default_nettype none

interface nir_res_if;
    import nir_pkg::*;

    logic                valid;
    logic                ready;
    logic                code_ready;
    logic [CODE_W-1:0]   frame_code;
    logic [BUTTON_W-1:0] button_code;
    logic [PHASE_W-1:0]  decoder_phase;

    modport source (output valid, code_ready, frame_code, button_code, decoder_phase,
                    input ready);
    modport sink   (input valid, code_ready, frame_code, button_code, decoder_phase,
                    output ready);
endinterface

`default_nettype wire

### src/nir_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on nir_pkg.
`default_nettype none

interface nir_cfg_if;
    import nir_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [US_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/nir_cfg_regs.sv
// Timing register bank of the NEC IR decoder, written over the config channel.
// Depends on nir_pkg and nir_cfg_if.
`default_nettype none

module nir_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    nir_cfg_if.sink           cfg,
    output nir_pkg::nir_cfg_t regs
);
    import nir_pkg::*;

    nir_cfg_t regs_reg;
    nir_cfg_t regs_next;
    logic     wr_beat;

    // Always ready; indexes past the last register are dropped
    assign cfg.ready = 1'b1;
    assign wr_beat   = cfg.valid & cfg.ready;

    // Register select
    always_comb
    begin
        regs_next = regs_reg;
        if (wr_beat)
        begin
            case (cfg.index)
                REG_LEADER_MARK_MIN:  regs_next.leader_mark_min  = cfg.data;
                REG_LEADER_MARK_MAX:  regs_next.leader_mark_max  = cfg.data;
                REG_LEADER_SPACE_MIN: regs_next.leader_space_min = cfg.data;
                REG_LEADER_SPACE_MAX: regs_next.leader_space_max = cfg.data;
                REG_PULSE_MIN:        regs_next.pulse_min        = cfg.data;
                REG_BIT_MARK_MAX:     regs_next.bit_mark_max     = cfg.data;
                REG_BIT_SPACE_MAX:    regs_next.bit_space_max    = cfg.data;
                REG_ONE_THRESHOLD:    regs_next.one_threshold    = cfg.data;
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.leader_mark_min  <= RST_LEADER_MARK_MIN;
            regs_reg.leader_mark_max  <= RST_LEADER_MARK_MAX;
            regs_reg.leader_space_min <= RST_LEADER_SPACE_MIN;
            regs_reg.leader_space_max <= RST_LEADER_SPACE_MAX;
            regs_reg.pulse_min        <= RST_PULSE_MIN;
            regs_reg.bit_mark_max     <= RST_BIT_MARK_MAX;
            regs_reg.bit_space_max    <= RST_BIT_SPACE_MAX;
            regs_reg.one_threshold    <= RST_ONE_THRESHOLD;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

### src/nec_ir_pulse_decoder.sv
// NEC infrared frame decoder driven by edge-timing events.
//
// Channels: evt carries one beat per IR edge (command = edge) with the
// microseconds since the previous edge, or a timer overflow (command =
// timeout). res returns exactly one beat per evt beat: code_ready,
// frame_code, button_code (code bits 15:8) and the phase after the step.
// cfg writes the eight 16-bit timing bounds; it is always ready and
// should be used only while no event is in flight.
// The result register puts each result on res in the cycle after its evt beat.
// Throughput: one event per cycle while res is not held off; the next-phase,
// range compares and code shift are all combinational between the decoder
// state and the result register.
// Stall: when res is held off, the result register keeps its beat and
// evt.ready drops until it is taken; evt.ready is high again in the
// same cycle that res.ready takes the pending beat.
// Reset: phase idle, bit count and code cleared, timing bounds back to
// the standard NEC values, no result pending.
// Depends on nir_pkg, the channel interfaces, nir_cfg_regs and the macros.
`default_nettype none

`include "nec_ir_pulse_decoder_macros.svh"

module nec_ir_pulse_decoder #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    nir_evt_if.sink   evt,
    nir_res_if.source res,
    nir_cfg_if.sink   cfg
);
    import nir_pkg::*;

    localparam logic [BITS_W-1:0] FRAME_LEN = BITS_W'(FRAME_BITS);
    localparam logic [BITS_W-1:0] BITS_SAT  = {BITS_W{1'b1}};

    nir_cfg_t tcfg;

    // Decoder state
    nir_phase_t        phase_reg, phase_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [CODE_W-1:0] code_reg, code_next;

    // Result register
    logic                res_valid_reg, res_valid_next;
    logic                ready_flag_reg, ready_flag_next;
    logic [CODE_W-1:0]   fcode_reg, fcode_next;
    logic [BUTTON_W-1:0] bcode_reg, bcode_next;
    logic [PHASE_W-1:0]  dphase_reg;

    logic              evt_beat;
    logic              is_timeout;
    logic              lmark_ok, lspace_ok, bmark_ok, bspace_ok;
    logic              bit_one;
    logic [BITS_W-1:0] bits_inc;
    logic              frame_done;
    logic [CODE_W-1:0] code_shifted;

    nir_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (tcfg)
    );

    // Handshake: accept whenever the result slot is free or being drained
    assign evt.ready  = !res_valid_reg || res.ready;
    assign evt_beat   = evt.valid && evt.ready;
    assign is_timeout = (evt.command == CMD_TIMEOUT);

    // Width checks, all bounds exclusive
    assign lmark_ok  = (tcfg.leader_mark_min < evt.elapsed_us)
                    && (evt.elapsed_us < tcfg.leader_mark_max);
    assign lspace_ok = (tcfg.leader_space_min < evt.elapsed_us)
                    && (evt.elapsed_us < tcfg.leader_space_max);
    assign bmark_ok  = (tcfg.pulse_min < evt.elapsed_us)
                    && (evt.elapsed_us < tcfg.bit_mark_max);
    assign bspace_ok = (tcfg.pulse_min < evt.elapsed_us)
                    && (evt.elapsed_us < tcfg.bit_space_max);
    assign bit_one   = (evt.elapsed_us > tcfg.one_threshold);

    // Bit count and shift for an accepted bit space
    assign bits_inc     = (bits_reg == BITS_SAT) ? bits_reg : bits_reg + 1'b1;
    assign frame_done   = (bits_inc >= FRAME_LEN);
    assign code_shifted = {code_reg[CODE_W-2:0], bit_one};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (evt_beat)
        begin
            if (is_timeout)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:   phase_next = PH_LMARK;
                    PH_LMARK:  phase_next = lmark_ok  ? PH_LSPACE : PH_IDLE;
                    PH_LSPACE: phase_next = lspace_ok ? PH_BMARK  : PH_IDLE;
                    PH_BMARK:  phase_next = bmark_ok  ? PH_BSPACE : PH_IDLE;
                    PH_BSPACE:
                    begin
                        if (bspace_ok && !frame_done)
                            phase_next = PH_BMARK;
                        else
                            phase_next = PH_IDLE;
                    end
                    // unused codes behave as idle: start a frame
                    default:   phase_next = PH_LMARK;
                endcase
            end
        end
    end

    // Datapath and result values
    always_comb
    begin
        bits_next       = bits_reg;
        code_next       = code_reg;
        ready_flag_next = 1'b0;
        fcode_next      = '0;
        bcode_next      = '0;
        if (evt_beat && !is_timeout)
        begin
            case (phase_reg)
                PH_LMARK, PH_LSPACE, PH_BMARK:
                begin
                    bits_next = bits_reg;
                end
                PH_BSPACE:
                begin
                    if (bspace_ok)
                    begin
                        bits_next = bits_inc;
                        code_next = code_shifted;
                        if (frame_done)
                        begin
                            ready_flag_next = 1'b1;
                            fcode_next      = code_shifted;
                            bcode_next      = code_shifted[15:8];
                        end
                    end
                end
                // idle or unused code: new frame
                default:
                begin
                    bits_next = '0;
                    code_next = '0;
                end
            endcase
        end
    end

    // Result slot occupancy
    always_comb
    begin
        if (evt_beat)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bits_reg      <= '0;
            code_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bits_reg      <= bits_next;
            code_reg      <= code_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload, loaded per accepted beat
    always_ff @(posedge clk)
    begin
        if (evt_beat)
        begin
            ready_flag_reg <= ready_flag_next;
            fcode_reg      <= fcode_next;
            bcode_reg      <= bcode_next;
            dphase_reg     <= PHASE_W'(phase_next);
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.code_ready    = ready_flag_reg;
    assign res.frame_code    = fcode_reg;
    assign res.button_code   = bcode_reg;
    assign res.decoder_phase = dphase_reg;

    // Checks
    `NIR_ASSERT_IMPL(a_done_goes_idle, res.valid && res.code_ready, res.decoder_phase == PH_IDLE)
    `NIR_ASSERT_IMPL(a_no_code_is_zero, res.valid && !res.code_ready, res.frame_code == '0)
    `NIR_ASSERT_IMPL(a_bits_bounded, phase_reg != PH_IDLE, bits_reg <= FRAME_LEN)
    `NIR_ASSERT_NEXT(a_beat_gives_result, evt_beat, res_valid_reg)

endmodule

`default_nettype wire

### bench/nec_ir_pulse_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the NEC IR pulse decoder: directed edge cases, then
// random frames under several timing-bound settings and random handshake gaps.
// Depends on nir_pkg, the nir_evt_if / nir_res_if / nir_cfg_if interfaces and the RTL.

module nec_ir_pulse_decoder_tb;
    import nir_pkg::*;

    localparam int unsigned FRAME_LEN        = 32;
    localparam int unsigned LONG_HOLD_CYCLES = 120;
    localparam int unsigned CYCLE_LIMIT      = 300000;
    localparam logic [US_W-1:0] US_MAX       = {US_W{1'b1}};

    // Expected decoder behavior: timing bounds, frame state and pending beats
    class nir_frame_scoreboard;
        typedef struct packed {
            logic                code_ready;
            logic [CODE_W-1:0]   frame_code;
            logic [BUTTON_W-1:0] button_code;
            nir_phase_t          phase;
        } decode_beat_t;

        nir_cfg_t           bounds;
        nir_phase_t         phase;
        logic [BITS_W-1:0]  rx_bits;
        logic [CODE_W-1:0]  shift_reg;
        decode_beat_t       expected[$];
        int unsigned        mismatches;

        function new();
            bounds.leader_mark_min  = RST_LEADER_MARK_MIN;
            bounds.leader_mark_max  = RST_LEADER_MARK_MAX;
            bounds.leader_space_min = RST_LEADER_SPACE_MIN;
            bounds.leader_space_max = RST_LEADER_SPACE_MAX;
            bounds.pulse_min        = RST_PULSE_MIN;
            bounds.bit_mark_max     = RST_BIT_MARK_MAX;
            bounds.bit_space_max    = RST_BIT_SPACE_MAX;
            bounds.one_threshold    = RST_ONE_THRESHOLD;
            phase       = PH_IDLE;
            rx_bits     = '0;
            shift_reg   = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [US_W-1:0] val);
            case (idx)
                REG_LEADER_MARK_MIN:  bounds.leader_mark_min  = val;
                REG_LEADER_MARK_MAX:  bounds.leader_mark_max  = val;
                REG_LEADER_SPACE_MIN: bounds.leader_space_min = val;
                REG_LEADER_SPACE_MAX: bounds.leader_space_max = val;
                REG_PULSE_MIN:        bounds.pulse_min        = val;
                REG_BIT_MARK_MAX:     bounds.bit_mark_max     = val;
                REG_BIT_SPACE_MAX:    bounds.bit_space_max    = val;
                REG_ONE_THRESHOLD:    bounds.one_threshold    = val;
                default: ; // unmapped index, write dropped
            endcase
        endfunction

        // exclusive window check
        function bit in_window(logic [US_W-1:0] t, logic [US_W-1:0] lo, logic [US_W-1:0] hi);
            return (lo < t) && (t < hi);
        endfunction

        // Advance the decoder by one event beat and queue the result it must produce
        function void note_event(logic cmd, logic [US_W-1:0] us);
            decode_beat_t r;
            r = '0;
            if (cmd == CMD_TIMEOUT)
            begin
                phase = PH_IDLE;
            end
            else
            begin
                case (phase)
                    PH_LMARK:
                        phase = in_window(us, bounds.leader_mark_min, bounds.leader_mark_max)
                                ? PH_LSPACE : PH_IDLE;
                    PH_LSPACE:
                        phase = in_window(us, bounds.leader_space_min, bounds.leader_space_max)
                                ? PH_BMARK : PH_IDLE;
                    PH_BMARK:
                        phase = in_window(us, bounds.pulse_min, bounds.bit_mark_max)
                                ? PH_BSPACE : PH_IDLE;
                    PH_BSPACE:
                    begin
                        if (in_window(us, bounds.pulse_min, bounds.bit_space_max))
                        begin
                            shift_reg = {shift_reg[CODE_W-2:0], us > bounds.one_threshold};
                            if (rx_bits != '1)
                                rx_bits = rx_bits + 1'b1;
                            if (rx_bits >= FRAME_LEN)
                            begin
                                r.code_ready  = 1'b1;
                                r.frame_code  = shift_reg;
                                r.button_code = shift_reg[15:8];
                                phase = PH_IDLE;
                            end
                            else
                            begin
                                phase = PH_BMARK;
                            end
                        end
                        else
                        begin
                            phase = PH_IDLE;
                        end
                    end
                    // idle (and any stray code): this edge opens a new frame
                    default:
                    begin
                        rx_bits   = '0;
                        shift_reg = '0;
                        phase     = PH_LMARK;
                    end
                endcase
            end
            r.phase = phase;
            expected.push_back(r);
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_result(logic cr, logic [CODE_W-1:0] fc,
                                   logic [BUTTON_W-1:0] bc, logic [PHASE_W-1:0] ph);
            decode_beat_t r;
            if (expected.size() == 0)
            begin
                $error("result beat with no event outstanding");
                mismatches++;
                return;
            end
            r = expected.pop_front();
            if (cr !== r.code_ready)
            begin
                $error("code_ready: expected %0d, actual %0d", r.code_ready, cr);
                mismatches++;
            end
            if (fc !== r.frame_code)
            begin
                $error("frame_code: expected %h, actual %h", r.frame_code, fc);
                mismatches++;
            end
            if (bc !== r.button_code)
            begin
                $error("button_code: expected %h, actual %h", r.button_code, bc);
                mismatches++;
            end
            if (ph !== r.phase)
            begin
                $error("decoder_phase: expected %0d, actual %0d", r.phase, ph);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nir_evt_if evt_ch ();
    nir_res_if res_ch ();
    nir_cfg_if cfg_ch ();

    nec_ir_pulse_decoder #(.FRAME_BITS(FRAME_LEN)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    nir_frame_scoreboard sb;
    bit          no_idle;
    bit          long_hold_req;
    int unsigned items_sent;
    int unsigned cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("nec_ir_pulse_decoder_tb: FAIL");
                $finish;
            end
        end
    end

    // Monitor: every accepted beat goes through the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_ch.valid && evt_ch.ready)
                sb.note_event(evt_ch.command, evt_ch.elapsed_us);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.code_ready, res_ch.frame_code,
                                res_ch.button_code, res_ch.decoder_phase);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // Result sink: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                stall = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // One event beat, after a random gap
    task automatic send_event(input logic cmd, input logic [US_W-1:0] us);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.command    <= cmd;
        evt_ch.elapsed_us <= us;
        do @(posedge clk); while (!evt_ch.ready);
        items_sent++;
    endtask

    // One register write beat; valid stays up for back-to-back writes
    task automatic write_reg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [US_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Stop offering events and wait for every result to come back
    task automatic drain();
        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Load all timing bounds, plus a write to an unmapped index
    task automatic program_bounds(input nir_cfg_t b);
        drain();
        write_reg_beat(REG_LEADER_MARK_MIN,  b.leader_mark_min);
        write_reg_beat(REG_LEADER_MARK_MAX,  b.leader_mark_max);
        write_reg_beat(REG_LEADER_SPACE_MIN, b.leader_space_min);
        write_reg_beat(REG_LEADER_SPACE_MAX, b.leader_space_max);
        write_reg_beat(REG_PULSE_MIN,        b.pulse_min);
        write_reg_beat(REG_BIT_MARK_MAX,     b.bit_mark_max);
        write_reg_beat(REG_BIT_SPACE_MAX,    b.bit_space_max);
        write_reg_beat(REG_ONE_THRESHOLD,    b.one_threshold);
        write_reg_beat(CFG_IDX_W'($urandom_range(REG_ONE_THRESHOLD + 1, {CFG_IDX_W{1'b1}})),
                       US_W'($urandom_range(0, US_MAX)));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Width strictly inside (lo, hi); any width if the window is empty
    function automatic logic [US_W-1:0] pick_inside_window(int unsigned lo, int unsigned hi);
        if (hi > lo + 1)
            return US_W'($urandom_range(hi - 1, lo + 1));
        return US_W'($urandom_range(0, US_MAX));
    endfunction

    // Width that fails the (lo, hi) window
    function automatic logic [US_W-1:0] pick_outside_window(int unsigned lo, int unsigned hi);
        if ($urandom_range(0, 1) == 0)
            return US_W'($urandom_range(0, lo));
        return US_W'($urandom_range(hi, US_MAX));
    endfunction

    // A full frame, or one broken by a timeout or bad width at a random spot
    task automatic send_frame(input bit broken);
        int unsigned cut;
        int unsigned lo;
        int unsigned hi;
        cut = broken ? $urandom_range(1, 2 + 2 * FRAME_LEN) : 0;
        send_event(CMD_EDGE, US_W'($urandom_range(0, US_MAX)));
        for (int unsigned pos = 1; pos <= 2 + 2 * FRAME_LEN; pos++)
        begin
            if (pos == 1)
            begin
                lo = 32'(sb.bounds.leader_mark_min);
                hi = 32'(sb.bounds.leader_mark_max);
            end
            else if (pos == 2)
            begin
                lo = 32'(sb.bounds.leader_space_min);
                hi = 32'(sb.bounds.leader_space_max);
            end
            else if (pos % 2 == 1)
            begin
                lo = 32'(sb.bounds.pulse_min);
                hi = 32'(sb.bounds.bit_mark_max);
            end
            else
            begin
                lo = 32'(sb.bounds.pulse_min);
                hi = 32'(sb.bounds.bit_space_max);
            end
            if (pos == cut)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_event(CMD_TIMEOUT, US_W'($urandom_range(0, US_MAX)));
                else
                    send_event(CMD_EDGE, pick_outside_window(lo, hi));
                return;
            end
            send_event(CMD_EDGE, pick_inside_window(lo, hi));
        end
    endtask

    // Random events with no frame structure
    task automatic send_noise(input int unsigned n);
        repeat (n)
            send_event($urandom_range(0, 3) == 0 ? CMD_TIMEOUT : CMD_EDGE,
                       US_W'($urandom_range(0, US_MAX)));
        if ($urandom_range(0, 1) == 0)
            send_event(CMD_TIMEOUT, US_W'($urandom_range(0, US_MAX)));
    endtask

    // Mostly well-formed frames, some broken ones and some noise
    task automatic run_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_frame(1'b0);
            else if (pick < 9)
                send_frame(1'b1);
            else
                send_noise($urandom_range(1, 8));
        end
        no_idle = 1'b0;
    endtask

    function automatic nir_cfg_t random_bounds();
        nir_cfg_t b;
        b.leader_mark_min  = US_W'($urandom_range(0, 40000));
        b.leader_mark_max  = US_W'(b.leader_mark_min + $urandom_range(2, 20000));
        b.leader_space_min = US_W'($urandom_range(0, 40000));
        b.leader_space_max = US_W'(b.leader_space_min + $urandom_range(2, 20000));
        b.pulse_min        = US_W'($urandom_range(0, 2000));
        b.bit_mark_max     = US_W'(b.pulse_min + $urandom_range(2, 3000));
        b.bit_space_max    = US_W'(b.pulse_min + $urandom_range(2, 6000));
        b.one_threshold    = US_W'($urandom_range(b.pulse_min, b.bit_space_max));
        return b;
    endfunction

    // Stimulus
    initial
    begin
        nir_cfg_t b;
        sb            = new();
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        items_sent    = 0;
        rst_n             <= 1'b0;
        evt_ch.valid      <= 1'b0;
        evt_ch.command    <= CMD_EDGE;
        evt_ch.elapsed_us <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: window edges at reset bounds, timeouts, first bits
        send_event(CMD_TIMEOUT, US_MAX);        // timeout while idle
        send_event(CMD_EDGE, 16'd0);            // start edge, width ignored
        send_event(CMD_EDGE, 16'd8500);         // leader mark at min: rejected
        send_event(CMD_EDGE, US_MAX);           // start again
        send_event(CMD_EDGE, 16'd9499);         // leader mark just inside
        send_event(CMD_EDGE, 16'd5000);         // leader space at max: rejected
        send_event(CMD_EDGE, 16'd0);
        send_event(CMD_EDGE, 16'd8501);
        send_event(CMD_EDGE, 16'd4001);
        send_event(CMD_EDGE, 16'd400);          // bit mark at pulse min: rejected
        send_event(CMD_EDGE, 16'd1);
        send_event(CMD_EDGE, 16'd9000);
        send_event(CMD_EDGE, 16'd4999);
        send_event(CMD_EDGE, 16'd699);
        send_event(CMD_EDGE, 16'd1800);         // bit space at max: rejected
        send_event(CMD_EDGE, 16'd0);
        send_event(CMD_EDGE, 16'd9000);
        send_event(CMD_EDGE, 16'd4500);
        send_event(CMD_EDGE, 16'd401);
        send_event(CMD_EDGE, 16'd1000);         // at threshold: zero
        send_event(CMD_EDGE, 16'd560);
        send_event(CMD_EDGE, 16'd1799);         // above threshold: one
        send_event(CMD_TIMEOUT, 16'd0);         // timeout mid-frame
        send_event(CMD_EDGE, 16'd0);
        send_event(CMD_TIMEOUT, 16'd0);         // timeout in leader mark

        // Reset bounds; receiver holds off once to back up the input
        drain();
        long_hold_req = 1'b1;
        run_traffic(180);

        // Random bounds
        program_bounds(random_bounds());
        run_traffic(150);

        // Wide-open windows, every bit space decodes as one
        b.leader_mark_min  = '0;
        b.leader_mark_max  = US_MAX;
        b.leader_space_min = '0;
        b.leader_space_max = US_MAX;
        b.pulse_min        = '0;
        b.bit_mark_max     = US_MAX;
        b.bit_space_max    = US_MAX;
        b.one_threshold    = '0;
        program_bounds(b);
        run_traffic(100);

        // Same, every bit space decodes as zero
        b.one_threshold = US_MAX;
        program_bounds(b);
        run_traffic(100);

        // Empty windows: nothing gets past the leader mark
        b.leader_mark_min  = US_MAX;
        b.leader_mark_max  = '0;
        b.leader_space_min = US_MAX;
        b.leader_space_max = '0;
        b.pulse_min        = US_MAX;
        b.bit_mark_max     = '0;
        b.bit_space_max    = '0;
        b.one_threshold    = US_MAX;
        program_bounds(b);
        run_traffic(40);

        // Back to the standard NEC timing
        b.leader_mark_min  = RST_LEADER_MARK_MIN;
        b.leader_mark_max  = RST_LEADER_MARK_MAX;
        b.leader_space_min = RST_LEADER_SPACE_MIN;
        b.leader_space_max = RST_LEADER_SPACE_MAX;
        b.pulse_min        = RST_PULSE_MIN;
        b.bit_mark_max     = RST_BIT_MARK_MAX;
        b.bit_space_max    = RST_BIT_SPACE_MAX;
        b.one_threshold    = RST_ONE_THRESHOLD;
        program_bounds(b);
        run_traffic(100);

        drain();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("nec_ir_pulse_decoder_tb: PASS");
        else
            $display("nec_ir_pulse_decoder_tb: FAIL");
        $finish;
    end

endmodule
